@@ design/psvm_pkg.sv @@
// Shared types and constants for the polyphonic sample voice mixer.
package psvm_pkg;

  // Item kinds carried on the input channel's tuser
  localparam logic [1:0] FUNC_SCAN  = 2'd0;
  localparam logic [1:0] FUNC_TICK  = 2'd1;
  localparam logic [1:0] FUNC_WRITE = 2'd2;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_PRESS_THRESHOLD = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NOTE_LENGTH     = 1'd1;

  // Field widths
  localparam int unsigned FUNC_W    = 2;
  localparam int unsigned KEY_W     = 4;
  localparam int unsigned READING_W = 17;
  localparam int unsigned SADDR_W   = 12;
  localparam int unsigned SVAL_W    = 8;
  localparam int unsigned THRESH_W  = 16;
  localparam int unsigned POS_W     = 12;
  localparam int unsigned LEVEL_W   = 8;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned IN_DATA_W  = 48;
  localparam int unsigned OUT_DATA_W = 8;

  // Input tdata field offsets
  localparam int unsigned KEY_LSB     = 0;
  localparam int unsigned READING_LSB = KEY_LSB + KEY_W;
  localparam int unsigned SADDR_LSB   = READING_LSB + READING_W;
  localparam int unsigned SVAL_LSB    = SADDR_LSB + SADDR_W;

  // Register reset values
  localparam logic [THRESH_W-1:0] THRESHOLD_RESET = 16'd20;
  localparam logic [POS_W-1:0]    LENGTH_RESET    = 12'd2400;

  // Controller to datapath commands
  typedef struct packed {
    logic scan;        // apply a key-scan reading
    logic write;       // store one sample byte
    logic tick_start;  // clear the mix sum and voice counter
    logic step;        // process the voice under the counter
    logic scale;       // multiply the sum by the reciprocal
    logic load_out;    // load the level into the output register
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic last_voice;  // counter is on the last voice
    logic out_free;    // output register can take a new level
  } sts_t;

endpackage

@@ design/psvm_ctrl.sv @@
// Controller state machine: sequences one tick over all voices.
module psvm_ctrl (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [psvm_pkg::FUNC_W-1:0]   in_func,
  input  psvm_pkg::sts_t                sts,
  output psvm_pkg::cmd_t                cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_RUN   = 3'd1;
  localparam logic [2:0] S_DRAIN = 3'd2;
  localparam logic [2:0] S_SCALE = 3'd3;
  localparam logic [2:0] S_OUT   = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic       accept;

  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;

  // Next state and command decode
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          unique case (in_func)
            psvm_pkg::FUNC_SCAN:  cmd.scan = 1'b1;
            psvm_pkg::FUNC_WRITE: cmd.write = 1'b1;
            psvm_pkg::FUNC_TICK: begin
              cmd.tick_start = 1'b1;
              state_nxt      = S_RUN;
            end
            default: ;
          endcase
        end
      end
      S_RUN: begin
        cmd.step = 1'b1;
        if (sts.last_voice) state_nxt = S_DRAIN;
      end
      S_DRAIN: state_nxt = S_SCALE;
      S_SCALE: begin
        cmd.scale = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

@@ design/psvm_datapath.sv @@
// Datapath: voice state, sample memory, mix accumulator and output scaling.
module psvm_datapath #(
  parameter int unsigned VOICES       = 12,
  parameter int unsigned SAMPLE_DEPTH = 4096
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  psvm_pkg::cmd_t                     cmd,
  output psvm_pkg::sts_t                     sts,
  input  logic [psvm_pkg::KEY_W-1:0]         key_number,
  input  logic signed [psvm_pkg::READING_W-1:0] reading,
  input  logic [psvm_pkg::SADDR_W-1:0]       sample_address,
  input  logic [psvm_pkg::SVAL_W-1:0]        sample_value,
  input  logic                               cfg_we,
  input  logic [psvm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [psvm_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [psvm_pkg::LEVEL_W-1:0]       pwm_level
);

  localparam int unsigned VIDX_W    = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int unsigned AW        = $clog2(SAMPLE_DEPTH);
  localparam int unsigned MW        = $clog2(VOICES * SAMPLE_DEPTH);
  localparam int unsigned MEM_DEPTH = VOICES * SAMPLE_DEPTH;
  localparam int unsigned SUM_W     = $clog2(255 * VOICES + 1);
  // floor(sum / VOICES) as an exact multiply by a rounded-up reciprocal
  localparam int unsigned SCL_SHIFT = SUM_W + $clog2(VOICES);
  localparam int unsigned RECIP_W   = SCL_SHIFT + 1;
  localparam longint unsigned RECIP =
    ((64'd1 << SCL_SHIFT) + VOICES - 1) / VOICES;
  localparam int unsigned PROD_W    = SUM_W + RECIP_W;

  // Configuration registers
  logic [psvm_pkg::THRESH_W-1:0] threshold_r, threshold_nxt;
  logic [psvm_pkg::POS_W-1:0]    length_r, length_nxt;

  // Per-voice state
  logic                       was_pressed_r [VOICES];
  logic                       was_pressed_nxt [VOICES];
  logic                       active_r [VOICES];
  logic                       active_nxt [VOICES];
  logic [psvm_pkg::POS_W-1:0] pos_r [VOICES];
  logic [psvm_pkg::POS_W-1:0] pos_nxt [VOICES];
  logic [AW-1:0]              addr_r [VOICES];
  logic [AW-1:0]              addr_nxt [VOICES];

  // Tick sequencing and mix
  logic [VIDX_W-1:0]          vidx_r, vidx_nxt;
  logic                       add_pend_r, add_pend_nxt;
  logic [SUM_W-1:0]           sum_r, sum_nxt;
  logic [PROD_W-1:0]          prod_r, prod_nxt;
  logic                       out_valid_r, out_valid_nxt;
  logic [psvm_pkg::LEVEL_W-1:0] level_r, level_nxt;

  // Sample memory
  logic [psvm_pkg::SVAL_W-1:0] sample_mem [MEM_DEPTH];
  logic [psvm_pkg::SVAL_W-1:0] rd_data_r;
  logic [MW-1:0]               rd_addr;
  logic [MW-1:0]               wr_addr;
  logic                        wr_en;

  // Scan and current-voice decode
  logic              key_ok;
  logic [VIDX_W-1:0] key_idx;
  logic              pressed;
  logic              cur_active;
  logic [psvm_pkg::POS_W-1:0] cur_pos;
  logic [AW-1:0]     cur_addr;
  logic [AW-1:0]     cur_addr_inc;
  logic              play;

  assign key_ok  = (32'(key_number) < VOICES);
  assign key_idx = VIDX_W'(key_number);
  assign pressed = !reading[psvm_pkg::READING_W-1] &&
                   (reading[psvm_pkg::THRESH_W-1:0] > threshold_r);

  assign cur_active   = active_r[vidx_r];
  assign cur_pos      = pos_r[vidx_r];
  assign cur_addr     = addr_r[vidx_r];
  assign cur_addr_inc = (cur_addr == AW'(SAMPLE_DEPTH - 1)) ? '0 : cur_addr + 1'b1;
  assign play         = cur_active && (cur_pos < length_r);

  assign rd_addr = MW'(vidx_r) * MW'(SAMPLE_DEPTH) + MW'(cur_addr_inc);
  assign wr_addr = MW'(key_number) * MW'(SAMPLE_DEPTH) + MW'(sample_address);
  assign wr_en   = cmd.write && key_ok && (32'(sample_address) < SAMPLE_DEPTH);

  assign sts.last_voice = (vidx_r == VIDX_W'(VOICES - 1));
  assign sts.out_free   = !out_valid_r || out_tready;

  assign out_tvalid = out_valid_r;
  assign pwm_level  = level_r;

  // Configuration writes
  always_comb begin
    threshold_nxt = threshold_r;
    length_nxt    = length_r;
    if (cfg_we) begin
      unique case (cfg_index)
        psvm_pkg::REG_PRESS_THRESHOLD: threshold_nxt = cfg_wdata;
        psvm_pkg::REG_NOTE_LENGTH:     length_nxt = cfg_wdata[psvm_pkg::POS_W-1:0];
        default: ;
      endcase
    end
  end

  // Voice state update: key scan or one tick step
  always_comb begin
    for (int v = 0; v < VOICES; v++) begin
      was_pressed_nxt[v] = was_pressed_r[v];
      active_nxt[v]      = active_r[v];
      pos_nxt[v]         = pos_r[v];
      addr_nxt[v]        = addr_r[v];
    end
    if (cmd.scan && key_ok) begin
      if (pressed && !was_pressed_r[key_idx]) begin
        active_nxt[key_idx] = 1'b1;
        pos_nxt[key_idx]    = '0;
        addr_nxt[key_idx]   = '0;
      end
      was_pressed_nxt[key_idx] = pressed;
    end
    if (cmd.step) begin
      if (play) begin
        pos_nxt[vidx_r]  = cur_pos + 1'b1;
        addr_nxt[vidx_r] = cur_addr_inc;
      end else begin
        active_nxt[vidx_r] = 1'b0;
        pos_nxt[vidx_r]    = '0;
        addr_nxt[vidx_r]   = '0;
      end
    end
  end

  // Tick counter, accumulator, scaling and output register
  always_comb begin
    vidx_nxt      = vidx_r;
    add_pend_nxt  = cmd.step && play;
    sum_nxt       = sum_r;
    prod_nxt      = prod_r;
    out_valid_nxt = out_valid_r;
    level_nxt     = level_r;
    if (cmd.tick_start) begin
      vidx_nxt = '0;
      sum_nxt  = '0;
    end else begin
      if (cmd.step) vidx_nxt = vidx_r + 1'b1;
      if (add_pend_r) sum_nxt = sum_r + SUM_W'(rd_data_r);
    end
    if (cmd.scale) prod_nxt = PROD_W'(sum_r) * PROD_W'(RECIP);
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
      level_nxt     = prod_r[SCL_SHIFT +: psvm_pkg::LEVEL_W];
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Sample memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) sample_mem[wr_addr] <= sample_value;
    rd_data_r <= sample_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r <= psvm_pkg::THRESHOLD_RESET;
      length_r    <= psvm_pkg::LENGTH_RESET;
      for (int v = 0; v < VOICES; v++) begin
        was_pressed_r[v] <= 1'b0;
        active_r[v]      <= 1'b0;
        pos_r[v]         <= '0;
        addr_r[v]        <= '0;
      end
      vidx_r      <= '0;
      add_pend_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      threshold_r <= threshold_nxt;
      length_r    <= length_nxt;
      for (int v = 0; v < VOICES; v++) begin
        was_pressed_r[v] <= was_pressed_nxt[v];
        active_r[v]      <= active_nxt[v];
        pos_r[v]         <= pos_nxt[v];
        addr_r[v]        <= addr_nxt[v];
      end
      vidx_r      <= vidx_nxt;
      add_pend_r  <= add_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    sum_r   <= sum_nxt;
    prod_r  <= prod_nxt;
    level_r <= level_nxt;
  end

endmodule

@@ design/polyphonic_sample_voice_mixer.sv @@
// Top level of the polyphonic sample voice mixer.
// Each input transaction is one of three kinds, chosen by in_tuser: a key
// scan or a sample-memory write is applied as it is accepted; a tick walks
// the voices one per cycle through the single read port of the sample
// memory, then the sum is scaled and the level loaded into the output
// register, and only then is the next transaction taken. A level still
// waiting in the output register holds a tick in its output state until
// the receiver takes it; otherwise the level sits there while the next
// transaction is taken. Scans and writes give no result; each tick gives
// one pwm_level, equal to the sum of the playing voices' samples divided
// by VOICES, rounded down.
// There is no clearing pass after reset: sample memory holds garbage until
// loaded, so load every table a voice will play before starting it.
module polyphonic_sample_voice_mixer #(
  parameter int unsigned VOICES       = 12,
  parameter int unsigned SAMPLE_DEPTH = 4096
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // key_number[3:0], reading[20:4], sample_address[32:21],
  // sample_value[40:33], zero fill above
  input  logic [psvm_pkg::IN_DATA_W-1:0]       in_tdata,
  // func[1:0]
  input  logic [psvm_pkg::FUNC_W-1:0]          in_tuser,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // pwm_level[7:0]
  output logic [psvm_pkg::OUT_DATA_W-1:0]      out_tdata,
  input  logic                                 cfg_we,
  input  logic [psvm_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [psvm_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

  psvm_pkg::cmd_t cmd;
  psvm_pkg::sts_t sts;

  psvm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_func   (in_tuser),
    .sts       (sts),
    .cmd       (cmd)
  );

  psvm_datapath #(
    .VOICES       (VOICES),
    .SAMPLE_DEPTH (SAMPLE_DEPTH)
  ) u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .key_number     (in_tdata[psvm_pkg::KEY_LSB +: psvm_pkg::KEY_W]),
    .reading        (in_tdata[psvm_pkg::READING_LSB +: psvm_pkg::READING_W]),
    .sample_address (in_tdata[psvm_pkg::SADDR_LSB +: psvm_pkg::SADDR_W]),
    .sample_value   (in_tdata[psvm_pkg::SVAL_LSB +: psvm_pkg::SVAL_W]),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .pwm_level      (out_tdata)
  );

endmodule

@@ verif/testbench.sv @@
// Self-checking testbench for the polyphonic sample voice mixer.
module testbench;

  localparam int unsigned NUM_VOICES   = 12;
  localparam int unsigned TABLE_DEPTH  = 4096;
  localparam int unsigned DRAIN_CYCLES = 24;
  localparam int unsigned CYCLE_LIMIT  = 3000000;
  // Table positions 1..PLAY_SPAN are loaded; positions played stay within it
  localparam int unsigned PLAY_SPAN    = 32;
  localparam int unsigned RAND_ITEMS   = 95;
  localparam logic [psvm_pkg::FUNC_W-1:0] FUNC_UNUSED = 2'd3;

  logic                                clk;
  logic                                rst_n;
  logic                                in_tvalid;
  logic                                in_tready;
  logic [psvm_pkg::IN_DATA_W-1:0]      in_tdata;
  logic [psvm_pkg::FUNC_W-1:0]         in_tuser;
  logic                                out_tvalid;
  logic                                out_tready;
  logic [psvm_pkg::OUT_DATA_W-1:0]     out_tdata;
  logic                                cfg_we;
  logic [psvm_pkg::CFG_IDX_W-1:0]      cfg_index;
  logic [psvm_pkg::CFG_DATA_W-1:0]     cfg_wdata;

  polyphonic_sample_voice_mixer i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Mixer state as the testbench tracks it
  logic [psvm_pkg::THRESH_W-1:0] thr_model;
  logic [psvm_pkg::POS_W-1:0]    len_model;
  logic                          key_down     [NUM_VOICES];
  logic                          voice_on     [NUM_VOICES];
  logic [psvm_pkg::POS_W-1:0]    voice_pos    [NUM_VOICES];
  logic [psvm_pkg::SVAL_W-1:0]   sample_bytes [NUM_VOICES*TABLE_DEPTH];

  logic [psvm_pkg::LEVEL_W-1:0] expected_levels[$];

  int unsigned errors;
  int unsigned items_sent;
  int unsigned levels_checked;
  int unsigned configs_set;
  int unsigned cycle_count;
  bit          tx_gaps_on;
  bit          rx_stalls_on;
  int unsigned hold_off_req;

  // Clock
  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Mixed level for one tick; updates the voice state
  function automatic logic [psvm_pkg::LEVEL_W-1:0] mix_tick();
    int unsigned sum;
    sum = 0;
    for (int v = 0; v < NUM_VOICES; v++) begin
      if (voice_on[v]) begin
        if (voice_pos[v] < len_model) begin
          voice_pos[v] = voice_pos[v] + 1'b1;
          sum += sample_bytes[v*TABLE_DEPTH + voice_pos[v]];
        end else begin
          voice_on[v]  = 1'b0;
          voice_pos[v] = '0;
        end
      end else begin
        voice_pos[v] = '0;
      end
    end
    return psvm_pkg::LEVEL_W'((sum * 255) / (255 * NUM_VOICES));
  endfunction

  // Apply one accepted transaction to the tracked state
  function automatic void apply_item(logic [psvm_pkg::FUNC_W-1:0] f,
                                     logic [psvm_pkg::IN_DATA_W-1:0] d);
    logic [psvm_pkg::KEY_W-1:0]     k;
    logic [psvm_pkg::READING_W-1:0] rd;
    logic [psvm_pkg::SADDR_W-1:0]   ad;
    logic [psvm_pkg::SVAL_W-1:0]    sv;
    int                             r;
    int                             t;
    bit                             pressed;
    k  = d[psvm_pkg::KEY_LSB +: psvm_pkg::KEY_W];
    rd = d[psvm_pkg::READING_LSB +: psvm_pkg::READING_W];
    ad = d[psvm_pkg::SADDR_LSB +: psvm_pkg::SADDR_W];
    sv = d[psvm_pkg::SVAL_LSB +: psvm_pkg::SVAL_W];
    case (f)
      psvm_pkg::FUNC_SCAN: begin
        if (k < NUM_VOICES) begin
          r = $signed(rd);
          t = thr_model;
          pressed = (r > t);
          if (pressed && !key_down[k]) begin
            voice_on[k]  = 1'b1;
            voice_pos[k] = '0;
          end
          key_down[k] = pressed;
        end
      end
      psvm_pkg::FUNC_TICK: expected_levels.push_back(mix_tick());
      psvm_pkg::FUNC_WRITE: begin
        if (k < NUM_VOICES)
          sample_bytes[k*TABLE_DEPTH + ad] = sv;
      end
      default: ;
    endcase
  endfunction

  // Monitor: check results, track config writes and accepted transactions
  always @(posedge clk) begin
    if (!rst_n) begin
      thr_model = psvm_pkg::THRESHOLD_RESET;
      len_model = psvm_pkg::LENGTH_RESET;
      for (int v = 0; v < NUM_VOICES; v++) begin
        key_down[v]  = 1'b0;
        voice_on[v]  = 1'b0;
        voice_pos[v] = '0;
      end
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_levels.size() == 0) begin
          $display("%0t: unexpected level, expected none, actual %0d", $time, out_tdata);
          errors++;
        end else begin
          logic [psvm_pkg::LEVEL_W-1:0] want;
          want = expected_levels.pop_front();
          levels_checked++;
          if (out_tdata !== want) begin
            $display("%0t: pwm_level mismatch, expected %0d, actual %0d",
                     $time, want, out_tdata);
            errors++;
          end
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          psvm_pkg::REG_PRESS_THRESHOLD: thr_model = cfg_wdata[psvm_pkg::THRESH_W-1:0];
          psvm_pkg::REG_NOTE_LENGTH:     len_model = cfg_wdata[psvm_pkg::POS_W-1:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready)
        apply_item(in_tuser, in_tdata);
    end
  end

  // Gap lengths: mostly none or short, a few long
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Receiver: random stalls plus a requested long hold-off
  initial begin
    int unsigned stall_left;
    int unsigned hold_left;
    stall_left = 0;
    hold_left  = 0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_req != 0) begin
        hold_left    = hold_off_req;
        hold_off_req = 0;
      end
      if (hold_left != 0) begin
        out_tready = 1'b0;
        hold_left--;
      end else if (stall_left != 0) begin
        out_tready = 1'b0;
        stall_left--;
      end else if (rx_stalls_on && $urandom_range(0, 3) == 0) begin
        out_tready = 1'b0;
        stall_left = pick_gap();
      end else begin
        out_tready = 1'b1;
      end
    end
  end

  // Offer one transaction and wait until it is taken
  task automatic send_item(input logic [psvm_pkg::FUNC_W-1:0] f,
                           input logic [psvm_pkg::KEY_W-1:0] k,
                           input logic [psvm_pkg::READING_W-1:0] rd,
                           input logic [psvm_pkg::SADDR_W-1:0] ad,
                           input logic [psvm_pkg::SVAL_W-1:0] sv);
    int unsigned gap;
    gap = tx_gaps_on ? pick_gap() : 0;
    repeat (gap) begin
      @(negedge clk);
      in_tvalid = 1'b0;
    end
    @(negedge clk);
    in_tvalid = 1'b1;
    in_tuser  = f;
    in_tdata  = {7'd0, sv, ad, rd, k};
    do begin
      @(posedge clk);
    end while (!in_tready);
    items_sent++;
  endtask

  // Unused fields carry random content
  task automatic send_scan(input logic [psvm_pkg::KEY_W-1:0] k,
                           input logic [psvm_pkg::READING_W-1:0] rd);
    send_item(psvm_pkg::FUNC_SCAN, k, rd, psvm_pkg::SADDR_W'($urandom),
              psvm_pkg::SVAL_W'($urandom));
  endtask

  task automatic send_tick();
    send_item(psvm_pkg::FUNC_TICK, psvm_pkg::KEY_W'($urandom),
              psvm_pkg::READING_W'($urandom), psvm_pkg::SADDR_W'($urandom),
              psvm_pkg::SVAL_W'($urandom));
  endtask

  task automatic send_write(input logic [psvm_pkg::KEY_W-1:0] k,
                            input logic [psvm_pkg::SADDR_W-1:0] ad,
                            input logic [psvm_pkg::SVAL_W-1:0] sv);
    send_item(psvm_pkg::FUNC_WRITE, k, psvm_pkg::READING_W'($urandom), ad, sv);
  endtask

  // Wait until every level is out and the block has settled
  task automatic drain();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (expected_levels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [psvm_pkg::CFG_IDX_W-1:0] idx,
                           input logic [psvm_pkg::CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    @(negedge clk);
    cfg_we    = 1'b0;
  endtask

  task automatic set_config(input logic [psvm_pkg::THRESH_W-1:0] thr,
                            input logic [psvm_pkg::POS_W-1:0] len);
    drain();
    write_reg(psvm_pkg::REG_PRESS_THRESHOLD, thr);
    write_reg(psvm_pkg::REG_NOTE_LENGTH, psvm_pkg::CFG_DATA_W'(len));
    configs_set++;
  endtask

  // Reading above the threshold; the max reading when the threshold is max
  function automatic logic [psvm_pkg::READING_W-1:0] press_reading();
    int unsigned lo;
    if (thr_model == 16'hFFFF) return psvm_pkg::READING_W'(65535);
    lo = thr_model + 1;
    if ($urandom_range(0, 1) == 0)
      return psvm_pkg::READING_W'($urandom_range(lo, (lo + 40 > 65535) ? 65535 : lo + 40));
    return psvm_pkg::READING_W'($urandom_range(lo, 65535));
  endfunction

  // Reading that counts as a release: timeout, random negative or at most threshold
  function automatic logic [psvm_pkg::READING_W-1:0] release_reading();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return (r == 0 && $urandom_range(0, 1)) ? 17'h1FFFF : 17'h1FFFE;
    if (r == 1) return {1'b1, 16'($urandom)};
    return psvm_pkg::READING_W'($urandom_range(0, thr_model));
  endfunction

  // Fill the playable part of every voice table so no unwritten byte is played
  task automatic test_preload();
    tx_gaps_on = 1'b0;
    for (int v = 0; v < NUM_VOICES; v++)
      for (int a = 1; a <= PLAY_SPAN; a++)
        send_write(psvm_pkg::KEY_W'(v), psvm_pkg::SADDR_W'(a),
                   psvm_pkg::SVAL_W'($urandom));
  endtask

  // Directed corners under the reset settings
  task automatic test_directed();
    tx_gaps_on   = 1'b1;
    rx_stalls_on = 1'b1;
    send_tick();                       // all voices idle
    send_scan(4'd0, 17'd21);           // just above threshold
    send_tick();
    send_tick();
    send_scan(4'd0, 17'd21);           // held key does not restart
    send_tick();
    send_scan(4'd0, 17'd20);           // equal to threshold: release
    send_scan(4'd0, 17'd65535);        // press again: restart at 0
    send_tick();
    send_scan(4'd11, 17'h1FFFF);       // timeout readings
    send_scan(4'd11, 17'h1FFFE);
    send_scan(4'd12, 17'd65535);       // keys out of range are ignored
    send_scan(4'd15, 17'd65535);
    send_write(4'd15, 12'd1, 8'hFF);
    send_write(4'd13, 12'hFFF, 8'h00);
    send_item(FUNC_UNUSED, 4'hF, 17'h1FFFF, 12'hFFF, 8'hFF);  // unused function code
    send_scan(4'd5, 17'd100);
    send_scan(4'd11, 17'd1000);
    send_tick();
    send_write(4'd0, 12'd3, 8'h00);
    send_write(4'd0, 12'd4, 8'hFF);
    send_tick();
    send_tick();
  endtask

  // Register extremes: threshold 0 and max, note length 0, 1 and max
  task automatic test_register_extremes();
    set_config(16'd0, 12'd1);
    for (int k = 0; k < NUM_VOICES; k++) send_scan(psvm_pkg::KEY_W'(k), 17'd0);
    send_scan(4'd2, 17'd1);            // one above zero threshold
    send_tick();
    send_tick();
    send_tick();
    set_config(16'hFFFF, 12'd0);
    send_scan(4'd3, 17'd65535);        // max reading cannot exceed max threshold
    send_tick();
    set_config(16'd0, 12'd0);
    send_scan(4'd4, 17'd50);           // zero length: stops at next tick
    send_tick();
    send_tick();
    set_config(16'd0, 12'd4095);       // longest note, played only a few steps
    send_scan(4'd7, 17'd100);
    for (int i = 0; i < 6; i++) send_tick();
  endtask

  // Notes played through to their end
  task automatic test_full_note();
    set_config(psvm_pkg::THRESHOLD_RESET, 12'd30);
    tx_gaps_on   = 1'b0;
    rx_stalls_on = 1'b0;
    for (int k = 0; k < NUM_VOICES; k++) send_scan(psvm_pkg::KEY_W'(k), 17'd0);
    send_scan(4'd0, 17'd500);
    send_scan(4'd6, 17'd800);
    send_scan(4'd11, 17'd65535);
    for (int i = 0; i < 32; i++) send_tick();
  endtask

  // Receiver holds off while ticks keep coming, so the input stalls
  task automatic test_backpressure();
    set_config(psvm_pkg::THRESHOLD_RESET, psvm_pkg::POS_W'(PLAY_SPAN));
    for (int k = 0; k < NUM_VOICES; k++) send_scan(psvm_pkg::KEY_W'(k), 17'd0);
    for (int k = 0; k < NUM_VOICES; k += 2) send_scan(psvm_pkg::KEY_W'(k), 17'd300);
    hold_off_req = 400;
    for (int i = 0; i < 30; i++) send_tick();
    tx_gaps_on   = 1'b1;
    rx_stalls_on = 1'b1;
  endtask

  // Random traffic over several register settings
  task automatic test_random();
    logic [psvm_pkg::THRESH_W-1:0] thr;
    logic [psvm_pkg::POS_W-1:0]    len;
    int unsigned                   r;
    logic [psvm_pkg::KEY_W-1:0]    k;
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: begin thr = 16'd20;             len = 12'd30;  end
        1: begin thr = 16'd0;              len = 12'd1;   end
        2: begin
          thr = 16'($urandom);
          len = psvm_pkg::POS_W'($urandom_range(1, PLAY_SPAN));
        end
        3: begin thr = 16'hFFFF;           len = 12'd10;  end
        4: begin thr = 16'd1000;           len = psvm_pkg::POS_W'(PLAY_SPAN); end
        default: begin thr = 16'($urandom_range(0, 3000)); len = 12'd0; end
      endcase
      set_config(thr, len);
      tx_gaps_on   = (phase != 1);
      rx_stalls_on = (phase != 4);
      for (int i = 0; i < RAND_ITEMS; i++) begin
        r = $urandom_range(0, 99);
        k = ($urandom_range(0, 9) == 0) ? psvm_pkg::KEY_W'($urandom_range(12, 15))
                                         : psvm_pkg::KEY_W'($urandom_range(0, 11));
        if (r < 42)
          send_tick();
        else if (r < 60)
          send_scan(k, press_reading());
        else if (r < 80)
          send_scan(k, release_reading());
        else if (r < 97)
          send_write(psvm_pkg::KEY_W'($urandom), psvm_pkg::SADDR_W'($urandom),
                     psvm_pkg::SVAL_W'($urandom));
        else
          send_item(FUNC_UNUSED, psvm_pkg::KEY_W'($urandom),
                    psvm_pkg::READING_W'($urandom), psvm_pkg::SADDR_W'($urandom),
                    psvm_pkg::SVAL_W'($urandom));
      end
    end
  endtask

  // Watchdog
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("TB_ERROR");
    $finish;
  end

  // Test sequence
  initial begin
    errors         = 0;
    items_sent     = 0;
    levels_checked = 0;
    configs_set    = 1;
    tx_gaps_on     = 1'b0;
    rx_stalls_on   = 1'b0;
    hold_off_req   = 0;
    rst_n          = 1'b0;
    in_tvalid      = 1'b0;
    in_tdata       = '0;
    in_tuser       = psvm_pkg::FUNC_SCAN;
    cfg_we         = 1'b0;
    cfg_index      = psvm_pkg::REG_PRESS_THRESHOLD;
    cfg_wdata      = '0;
    repeat (4) @(negedge clk);
    rst_n = 1'b1;

    test_preload();
    test_directed();
    test_register_extremes();
    test_full_note();
    test_backpressure();
    test_random();
    drain();

    $display("Sent %0d transactions (table loads, scans, ticks, ignored codes)", items_sent);
    $display("Checked %0d mixed levels across %0d register settings, %0d mismatches",
             levels_checked, configs_set, errors);
    if (errors == 0 && expected_levels.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
